// ===== hw/rtl/fgn_pkg.sv =====
// Shared constants, codes and types of the fractal gradient noise block.
package fgn_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int PIXEL_BITS  = 12;

    localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
    localparam int COORD_W = 24;
    localparam int OFS_W   = 2 * COORD_W;
    localparam int PXIS_W  = PIXEL_BITS + COORD_W;
    localparam int PXIS_LO = PXIS_W / 2;
    localparam int PXIS_HI = PXIS_W - PXIS_LO;

    localparam logic [1:0] KIND_PERM   = 2'd0;
    localparam logic [1:0] KIND_OFFSET = 2'd1;
    localparam logic [1:0] KIND_EVAL   = 2'd2;

    localparam logic [7:0] CFG_OCTAVES     = 8'd0;
    localparam logic [7:0] CFG_INV_SCALE   = 8'd1;
    localparam logic [7:0] CFG_PERSISTENCE = 8'd2;
    localparam logic [7:0] CFG_LACUNARITY  = 8'd3;

    localparam logic [19:0] FREQ_MAX = 20'hFFFFF;
    localparam logic [16:0] AMP_MAX  = 17'h1FFFF;
    localparam logic [16:0] Q_ONE    = 17'h10000;

    localparam logic signed [27:0] HEIGHT_MAX = 28'sd4194303;
    localparam logic signed [27:0] HEIGHT_MIN = -28'sd4194304;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/fgn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fgn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fgn_cell.sv =====
// One octave offset cell of the rotating offset ring.
module fgn_cell (
    input  logic                      i_clk,
    input  fgn_pkg::t_cell_ctl        i_ctl,
    input  logic [fgn_pkg::OFS_W-1:0] i_load_data,
    input  logic [fgn_pkg::OFS_W-1:0] i_prev,
    output logic [fgn_pkg::OFS_W-1:0] o_data
);

    logic [fgn_pkg::OFS_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_load_data;
        end else if (i_ctl.shift) begin
            r_data <= i_prev;
        end
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/fbm_gradient_noise_point_top.sv =====
// Top level: fractal 2D gradient noise evaluator at one pixel.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+---------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser kind, tdata load/evaluate fields
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata height
//  cfg      | in  | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Load transactions are written as they are accepted. An evaluate runs each octave in 15
// steps on the shared noise datapath, bound by six reads of the single permutation RAM port.
// The offset ring rotates once per octave and finishes a full turn before the result.
// Reset clears control and sets configuration to defaults; RAM and offset cells hold garbage
// until loaded. A stalled result sits in the output register while the next item is taken.
module fbm_gradient_noise_point_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] entry_index, [15:8] perm_value, [39:16] offset_x, [63:40] offset_y,
    // [75:64] pixel_x, [87:76] pixel_y
    input  logic [87:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [22:0] height, [23] zero
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int OW = fgn_pkg::OCT_W;
    localparam int PB = fgn_pkg::PIXEL_BITS;
    localparam int MO = fgn_pkg::MAX_OCTAVES;
    localparam int FW = fgn_pkg::PXIS_W + 20;

    // per-octave step codes
    localparam logic [3:0] SP_MUL   = 4'd0;
    localparam logic [3:0] SP_SAMP  = 4'd1;
    localparam logic [3:0] SP_RD_X0 = 4'd2;
    localparam logic [3:0] SP_RD_X1 = 4'd3;
    localparam logic [3:0] SP_RD_A0 = 4'd4;
    localparam logic [3:0] SP_RD_A1 = 4'd5;
    localparam logic [3:0] SP_RD_B0 = 4'd6;
    localparam logic [3:0] SP_RD_B1 = 4'd7;
    localparam logic [3:0] SP_H11   = 4'd8;
    localparam logic [3:0] SP_LX_M  = 4'd9;
    localparam logic [3:0] SP_LX_A  = 4'd10;
    localparam logic [3:0] SP_LY_M  = 4'd11;
    localparam logic [3:0] SP_LY_A  = 4'd12;
    localparam logic [3:0] SP_AMP   = 4'd13;
    localparam logic [3:0] SP_ACC   = 4'd14;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_OCT,
        ST_ROT,
        ST_DONE
    } t_state;

    function automatic logic signed [18:0] grad(input logic [7:0] h,
                                                 input logic signed [17:0] x,
                                                 input logic signed [17:0] y);
        logic signed [18:0] gx;
        logic signed [18:0] gy;
        gx = h[0] ? -19'(x) : 19'(x);
        gy = h[1] ? -19'(y) : 19'(y);
        return gx + gy;
    endfunction

    // configuration
    logic [3:0]  r_octaves;
    logic [23:0] r_inv_scale;
    logic [16:0] r_pers;
    logic [19:0] r_lac;

    // control
    t_state      r_state;
    logic [3:0]  r_step;
    logic [OW-1:0] r_rot;
    logic        r_out_valid;
    logic [22:0] r_out_height;

    // datapath
    logic [PB-1:0] r_px, r_py;
    logic [fgn_pkg::PXIS_W-1:0] r_pxis, r_pyis;
    logic [fgn_pkg::PXIS_HI+19:0] r_mxh, r_myh;
    logic [fgn_pkg::PXIS_LO+19:0] r_mxl, r_myl;
    logic [23:0] r_sx, r_sy;
    logic [31:0] r_t2x, r_t2y;
    logic [15:0] r_cx, r_cy;
    logic [19:0] r_qx, r_qy;
    logic [16:0] r_u, r_v;
    logic [7:0]  r_a, r_b, r_h00, r_h01, r_h10, r_h11;
    logic signed [37:0] r_m0, r_m1;
    logic signed [21:0] r_x1, r_x2;
    logic signed [40:0] r_m2;
    logic signed [23:0] r_val;
    logic signed [41:0] r_prod;
    logic signed [27:0] r_sum;
    logic [19:0] r_freq;
    logic [16:0] r_amp;

    logic w_in_acc;
    logic w_rot;
    logic [OW-1:0] w_n;
    logic [7:0] w_raddr, w_rdata;
    logic [fgn_pkg::OFS_W-1:0] w_cell [MO];
    fgn_pkg::t_cell_ctl w_ctl [MO];

    logic [7:0]  w_idx;
    logic [11:0] w_pxf, w_pyf;
    logic [FW-1:0] w_fullx, w_fully;
    logic [47:0] w_t3x, w_t3y;
    logic [36:0] w_qx, w_qy;
    logic [35:0] w_fdx, w_fdy;
    logic signed [17:0] w_fx0, w_fx1, w_fy0, w_fy1;
    logic signed [18:0] w_g00, w_g10, w_g01, w_g11;
    logic signed [19:0] w_d0, w_d1;
    logic signed [22:0] w_d2;
    logic signed [21:0] w_n_q;
    logic signed [27:0] w_sum_next;
    logic [39:0] w_fp;
    logic [33:0] w_ap;
    logic [22:0] w_sat;
    logic [OW-1:0] w_rot_inc;

    assign w_idx = s_axis_tdata[7:0];
    assign w_pxf = s_axis_tdata[75:64];
    assign w_pyf = s_axis_tdata[87:76];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_height};

    // octave count clamped to the ring length
    always_comb begin
        if (5'(r_octaves) > 5'(MO)) begin
            w_n = OW'(MO);
        end else begin
            w_n = OW'(r_octaves);
        end
    end

    assign w_rot_inc = r_rot + OW'(1);
    assign w_rot = (r_state == ST_OCT && r_step == SP_ACC) ||
                   (r_state == ST_ROT && r_rot != OW'(MO));

    // offset ring: cell 0 is the current octave, x in the upper half
    for (genvar k = 0; k < MO; k++) begin : g_cell
        localparam int NXT = (k + 1) % MO;
        assign w_ctl[k].load  = w_in_acc && s_axis_tuser == fgn_pkg::KIND_OFFSET &&
                                w_idx == 8'(k);
        assign w_ctl[k].shift = w_rot;
        fgn_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[k]),
            .i_load_data ({s_axis_tdata[39:16], s_axis_tdata[63:40]}),
            .i_prev      (w_cell[NXT]),
            .o_data      (w_cell[k])
        );
    end

    // permutation table
    always_comb begin
        case (r_step)
            SP_RD_X0: w_raddr = r_sx[23:16];
            SP_RD_X1: w_raddr = r_sx[23:16] + 8'd1;
            SP_RD_A0: w_raddr = r_a;
            SP_RD_A1: w_raddr = r_a + 8'd1;
            SP_RD_B0: w_raddr = r_b;
            SP_RD_B1: w_raddr = r_b + 8'd1;
            default:  w_raddr = r_a;
        endcase
    end

    fgn_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && s_axis_tuser == fgn_pkg::KIND_PERM),
        .i_waddr (w_idx),
        .i_wdata (s_axis_tdata[15:8]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sample point: (p*inv_scale*freq) >> 16 plus offset, modulo 256.0
    assign w_fullx = (FW'(r_mxh) << fgn_pkg::PXIS_LO) + FW'(r_mxl);
    assign w_fully = (FW'(r_myh) << fgn_pkg::PXIS_LO) + FW'(r_myl);

    // quintic fade pieces
    assign w_t3x = 48'(r_t2x) * 48'(r_sx[15:0]);
    assign w_t3y = 48'(r_t2y) * 48'(r_sy[15:0]);
    assign w_qx  = (37'd10 << 32) + 37'd6 * 37'(r_t2x) - 37'd15 * (37'(r_sx[15:0]) << 16);
    assign w_qy  = (37'd10 << 32) + 37'd6 * 37'(r_t2y) - 37'd15 * (37'(r_sy[15:0]) << 16);
    assign w_fdx = 36'(r_cx) * 36'(r_qx);
    assign w_fdy = 36'(r_cy) * 36'(r_qy);

    // gradients at the four corners
    assign w_fx0 = $signed({2'b00, r_sx[15:0]});
    assign w_fy0 = $signed({2'b00, r_sy[15:0]});
    assign w_fx1 = w_fx0 - 18'sd65536;
    assign w_fy1 = w_fy0 - 18'sd65536;
    assign w_g00 = grad(r_h00, w_fx0, w_fy0);
    assign w_g10 = grad(r_h10, w_fx1, w_fy0);
    assign w_g01 = grad(r_h01, w_fx0, w_fy1);
    assign w_g11 = grad(r_h11, w_fx1, w_fy1);
    assign w_d0  = 20'(w_g10) - 20'(w_g00);
    assign w_d1  = 20'(w_g11) - 20'(w_g01);
    assign w_d2  = 23'(r_x2) - 23'(r_x1);
    assign w_n_q = r_x1 + 22'(r_m2 >>> 16);

    assign w_sum_next = r_sum + 28'(r_prod >>> 16);
    assign w_fp = 40'(r_freq) * 40'(r_lac);
    assign w_ap = 34'(r_amp) * 34'(r_pers);

    always_comb begin
        if (r_sum > fgn_pkg::HEIGHT_MAX) begin
            w_sat = fgn_pkg::HEIGHT_MAX[22:0];
        end else if (r_sum < fgn_pkg::HEIGHT_MIN) begin
            w_sat = fgn_pkg::HEIGHT_MIN[22:0];
        end else begin
            w_sat = r_sum[22:0];
        end
    end

    // datapath registers, advanced by the step counter
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px   <= PB'(w_pxf);
            r_py   <= PB'(w_pyf);
            r_sum  <= '0;
            r_freq <= 20'(fgn_pkg::Q_ONE);
            r_amp  <= fgn_pkg::Q_ONE;
        end
        if (r_state == ST_PREP) begin
            r_pxis <= fgn_pkg::PXIS_W'(r_px) * fgn_pkg::PXIS_W'(r_inv_scale);
            r_pyis <= fgn_pkg::PXIS_W'(r_py) * fgn_pkg::PXIS_W'(r_inv_scale);
        end
        if (r_state == ST_OCT) begin
            case (r_step)
                SP_MUL: begin
                    r_mxh <= (fgn_pkg::PXIS_HI + 20)'(r_pxis[fgn_pkg::PXIS_W-1:fgn_pkg::PXIS_LO])
                             * (fgn_pkg::PXIS_HI + 20)'(r_freq);
                    r_myh <= (fgn_pkg::PXIS_HI + 20)'(r_pyis[fgn_pkg::PXIS_W-1:fgn_pkg::PXIS_LO])
                             * (fgn_pkg::PXIS_HI + 20)'(r_freq);
                    r_mxl <= (fgn_pkg::PXIS_LO + 20)'(r_pxis[fgn_pkg::PXIS_LO-1:0])
                             * (fgn_pkg::PXIS_LO + 20)'(r_freq);
                    r_myl <= (fgn_pkg::PXIS_LO + 20)'(r_pyis[fgn_pkg::PXIS_LO-1:0])
                             * (fgn_pkg::PXIS_LO + 20)'(r_freq);
                end
                SP_SAMP: begin
                    r_sx <= w_fullx[39:16] + w_cell[0][47:24];
                    r_sy <= w_fully[39:16] + w_cell[0][23:0];
                end
                SP_RD_X0: begin
                    r_t2x <= 32'(r_sx[15:0]) * 32'(r_sx[15:0]);
                    r_t2y <= 32'(r_sy[15:0]) * 32'(r_sy[15:0]);
                end
                SP_RD_X1: begin
                    r_a  <= w_rdata + r_sy[23:16];
                    r_cx <= w_t3x[47:32];
                    r_cy <= w_t3y[47:32];
                    r_qx <= w_qx[35:16];
                    r_qy <= w_qy[35:16];
                end
                SP_RD_A0: begin
                    r_b <= w_rdata + r_sy[23:16];
                    r_u <= w_fdx[32:16];
                    r_v <= w_fdy[32:16];
                end
                SP_RD_A1: r_h00 <= w_rdata;
                SP_RD_B0: r_h01 <= w_rdata;
                SP_RD_B1: r_h10 <= w_rdata;
                SP_H11:   r_h11 <= w_rdata;
                SP_LX_M: begin
                    r_m0 <= 38'(w_d0) * 38'($signed({1'b0, r_u}));
                    r_m1 <= 38'(w_d1) * 38'($signed({1'b0, r_u}));
                end
                SP_LX_A: begin
                    r_x1 <= 22'(w_g00) + 22'(r_m0 >>> 16);
                    r_x2 <= 22'(w_g01) + 22'(r_m1 >>> 16);
                end
                SP_LY_M: r_m2 <= 41'(w_d2) * 41'($signed({1'b0, r_v}));
                SP_LY_A: r_val <= 24'(w_n_q) * 24'sd2 - 24'sd65536;
                SP_AMP:  r_prod <= 42'(r_val) * 42'($signed({1'b0, r_amp}));
                SP_ACC: begin
                    r_sum <= w_sum_next;
                    r_freq <= (w_fp[39:36] != 4'd0) ? fgn_pkg::FREQ_MAX : w_fp[35:16];
                    r_amp  <= w_ap[33] ? fgn_pkg::AMP_MAX : w_ap[32:16];
                end
                default: ;
            endcase
        end
    end

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= SP_MUL;
            r_rot        <= '0;
            r_out_valid  <= 1'b0;
            r_out_height <= '0;
            r_octaves    <= 4'd4;
            r_inv_scale  <= 24'd655360;
            r_pers       <= 17'd32768;
            r_lac        <= 20'd131072;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    fgn_pkg::CFG_OCTAVES:     r_octaves   <= i_cfg_data[3:0];
                    fgn_pkg::CFG_INV_SCALE:   r_inv_scale <= i_cfg_data;
                    fgn_pkg::CFG_PERSISTENCE: r_pers      <= i_cfg_data[16:0];
                    fgn_pkg::CFG_LACUNARITY:  r_lac       <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
            // ST_DONE refills the output register itself
            if (m_axis_tready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (w_rot) begin
                r_rot <= w_rot_inc;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && s_axis_tuser == fgn_pkg::KIND_EVAL) begin
                        r_state <= ST_PREP;
                        r_rot   <= '0;
                    end
                end
                ST_PREP: begin
                    r_step  <= SP_MUL;
                    r_state <= (w_n == '0) ? ST_ROT : ST_OCT;
                end
                ST_OCT: begin
                    if (r_step == SP_ACC) begin
                        r_step <= SP_MUL;
                        if (w_rot_inc == w_n) begin
                            r_state <= ST_ROT;
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_ROT: begin
                    if (r_rot == OW'(MO)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_height <= w_sat;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
